// File: src/luma_vertical_subpel_interp_defines.svh
// assertion macros shared by the luma vertical sub-pel interpolator
// no dependencies; included by files that carry assertions
`ifndef LUMA_VERTICAL_SUBPEL_INTERP_DEFINES_SVH
`define LUMA_VERTICAL_SUBPEL_INTERP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LVSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lvsi assertion failed");

// next-cycle implication, checked outside reset
`define LVSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lvsi assertion failed");

`endif

// File: src/lvsi_pkg.sv
// shared constants, types and codes of the luma vertical sub-pel interpolator
// no dependencies
package lvsi_pkg;

    localparam int LANES        = 4;
    localparam int WORD_LANES   = 4;
    localparam int ACTIVE_LANES = (LANES < WORD_LANES) ? LANES : WORD_LANES;
    localparam int PIX_W        = 8;
    localparam int WORD_W       = WORD_LANES * PIX_W;
    localparam int TAPS         = 6;
    localparam int WINDOW_ROWS  = 5;
    localparam int ROWS_PER_BLOCK = 9;
    localparam int CNT_W        = 4;
    localparam int SUM_W        = 16;
    localparam int ROUND_ADD    = 16;
    localparam int SHIFT_AMT    = 5;

    localparam logic [CNT_W-1:0] IDLE_COUNT = CNT_W'(ROWS_PER_BLOCK);
    localparam logic [CNT_W-1:0] FIRST_OUT  = CNT_W'(WINDOW_ROWS);
    localparam logic [CNT_W-1:0] LAST_OUT   = CNT_W'(ROWS_PER_BLOCK - 1);

    typedef enum logic [1:0] {
        MODE_FULL       = 2'd0,
        MODE_QUARTER_LO = 2'd1,
        MODE_HALF       = 2'd2,
        MODE_QUARTER_HI = 2'd3
    } t_frac_mode;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [WORD_LANES-1:0] t_lane_pix;
    typedef t_pix [TAPS-1:0] t_taps;

    typedef struct packed {
        logic produce;
        logic last;
    } t_row_ctrl;

endpackage

// File: src/lvsi_stream_if.sv
// handshake channels of the interpolator: reference rows in, predicted rows out
// depends on lvsi_pkg
interface lvsi_row_if;
    logic                       valid;
    logic                       ready;
    logic                       block_start;
    logic [1:0]                 frac_mode;
    logic [lvsi_pkg::WORD_W-1:0] row_pixels;

    modport source (output valid, block_start, frac_mode, row_pixels, input ready);
    modport sink   (input valid, block_start, frac_mode, row_pixels, output ready);
endinterface

interface lvsi_pred_if;
    logic                       valid;
    logic                       ready;
    logic [lvsi_pkg::WORD_W-1:0] pred_pixels;
    logic                       last_row;

    modport source (output valid, pred_pixels, last_row, input ready);
    modport sink   (input valid, pred_pixels, last_row, output ready);
endinterface

// File: src/lvsi_lane.sv
// one pixel lane: six-tap vertical filter, clip, and quarter-pel averaging
// depends on lvsi_pkg
module lvsi_lane (
    input  lvsi_pkg::t_taps      i_taps,
    input  lvsi_pkg::t_frac_mode i_mode,
    output lvsi_pkg::t_pix       o_pix
);

    logic signed [lvsi_pkg::SUM_W-1:0] outer;
    logic signed [lvsi_pkg::SUM_W-1:0] inner;
    logic signed [lvsi_pkg::SUM_W-1:0] center;
    logic signed [lvsi_pkg::SUM_W-1:0] sum;
    logic        [lvsi_pkg::SUM_W-1:0] shifted;
    lvsi_pkg::t_pix                     half;
    logic        [lvsi_pkg::PIX_W:0]   avg_c;
    logic        [lvsi_pkg::PIX_W:0]   avg_d;

    always_comb begin
        outer  = $signed({8'd0, i_taps[0]}) + $signed({8'd0, i_taps[5]});
        inner  = $signed({8'd0, i_taps[1]}) + $signed({8'd0, i_taps[4]});
        center = $signed({8'd0, i_taps[2]}) + $signed({8'd0, i_taps[3]});
        sum    = outer - (inner <<< 2) - inner + (center <<< 4) + (center <<< 2)
                 + lvsi_pkg::SUM_W'(lvsi_pkg::ROUND_ADD);
        shifted = lvsi_pkg::SUM_W'(sum >>> lvsi_pkg::SHIFT_AMT);
        // negative sums clip to zero, large ones saturate
        if (sum[lvsi_pkg::SUM_W-1]) begin
            half = '0;
        end else if (shifted > lvsi_pkg::SUM_W'(255)) begin
            half = '1;
        end else begin
            half = shifted[lvsi_pkg::PIX_W-1:0];
        end
        avg_c = ({1'b0, half} + {1'b0, i_taps[2]} + 9'd1) >> 1;
        avg_d = ({1'b0, half} + {1'b0, i_taps[3]} + 9'd1) >> 1;
        case (i_mode)
            lvsi_pkg::MODE_FULL:       o_pix = i_taps[2];
            lvsi_pkg::MODE_QUARTER_LO: o_pix = avg_c[lvsi_pkg::PIX_W-1:0];
            lvsi_pkg::MODE_HALF:       o_pix = half;
            lvsi_pkg::MODE_QUARTER_HI: o_pix = avg_d[lvsi_pkg::PIX_W-1:0];
            default:                   o_pix = i_taps[2];
        endcase
    end

endmodule

// File: src/lvsi_merge.sv
// merge stage: packs lane pixels into one word and holds it in the output register
// depends on lvsi_pkg and lvsi_stream_if
module lvsi_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  lvsi_pkg::t_row_ctrl   i_ctrl,
    input  lvsi_pkg::t_lane_pix   i_lane_pix,
    output logic                  o_ready,
    lvsi_pred_if.source           o_pred
);

    logic                        r_valid;
    logic                        n_valid;
    logic [lvsi_pkg::WORD_W-1:0] r_pixels;
    logic                        r_last;

    // room when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || o_pred.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_take) begin
            n_valid = i_ctrl.produce;
        end else if (o_pred.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_ctrl.produce) begin
            r_pixels <= i_lane_pix;
            r_last   <= i_ctrl.last;
        end
    end

    assign o_pred.valid       = r_valid;
    assign o_pred.pred_pixels = r_pixels;
    assign o_pred.last_row    = r_last;

endmodule

// File: src/luma_vertical_subpel_interp.sv
// Vertical six-tap luma sub-pel interpolator for 4x4 blocks.
// Input channel i_row carries one reference row word per handshake: four
// 8-bit pixels, byte 0 leftmost, plus block_start and frac_mode. A block is
// nine rows, top to bottom, starting two rows above the predicted block;
// block_start marks the first, and frac_mode is latched with it.
// Output channel o_pred carries one predicted row word for each of the
// sixth to ninth rows; last_row flags the fourth output row.
// A result word appears in the cycle after the row that causes it is taken.
// Throughput: one row word per cycle while the receiver does not stall; the lanes
// filter combinationally and the result lands in a single output register.
// When the receiver stalls, the output register holds its word and i_row
// stays ready only if that word leaves in the same cycle.
// Reset clears the five-row window, the held mode and the output valid; the
// block comes up idle, and rows without block_start then pass through the
// window without producing output. A new block_start mid-block restarts.
// depends on lvsi_pkg, lvsi_stream_if, lvsi_lane, lvsi_merge and the defines header
`include "luma_vertical_subpel_interp_defines.svh"

module luma_vertical_subpel_interp (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lvsi_row_if.sink     i_row,
    lvsi_pred_if.source  o_pred
);

    logic [lvsi_pkg::WINDOW_ROWS-1:0][lvsi_pkg::WORD_W-1:0] r_window;
    logic [lvsi_pkg::CNT_W-1:0]  r_count;
    logic [lvsi_pkg::CNT_W-1:0]  n_count;
    logic [lvsi_pkg::CNT_W-1:0]  eff_count;
    lvsi_pkg::t_frac_mode         r_mode;
    lvsi_pkg::t_frac_mode         eff_mode;
    logic                         take;
    logic                         merge_ready;
    lvsi_pkg::t_row_ctrl          ctrl;
    lvsi_pkg::t_lane_pix          lane_pix;

    assign i_row.ready = merge_ready;
    assign take        = i_row.valid && merge_ready;

    always_comb begin
        eff_count = i_row.block_start ? '0 : r_count;
        eff_mode  = i_row.block_start ? lvsi_pkg::t_frac_mode'(i_row.frac_mode) : r_mode;
        ctrl.produce = (eff_count >= lvsi_pkg::FIRST_OUT) && (eff_count <= lvsi_pkg::LAST_OUT);
        ctrl.last    = (eff_count == lvsi_pkg::LAST_OUT);
        n_count = (eff_count < lvsi_pkg::IDLE_COUNT) ? eff_count + 1'b1 : eff_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_count  <= lvsi_pkg::IDLE_COUNT;
            r_mode   <= lvsi_pkg::MODE_FULL;
        end else if (take) begin
            for (int i = 0; i < lvsi_pkg::WINDOW_ROWS - 1; i++) begin
                r_window[i] <= r_window[i+1];
            end
            r_window[lvsi_pkg::WINDOW_ROWS-1] <= i_row.row_pixels;
            r_count <= n_count;
            r_mode  <= eff_mode;
        end
    end

    for (genvar l = 0; l < lvsi_pkg::WORD_LANES; l++) begin : g_lane
        if (l < lvsi_pkg::ACTIVE_LANES) begin : g_on
            lvsi_pkg::t_taps taps;
            always_comb begin
                for (int t = 0; t < lvsi_pkg::WINDOW_ROWS; t++) begin
                    taps[t] = r_window[t][l*lvsi_pkg::PIX_W +: lvsi_pkg::PIX_W];
                end
                taps[lvsi_pkg::TAPS-1] = i_row.row_pixels[l*lvsi_pkg::PIX_W +: lvsi_pkg::PIX_W];
            end
            lvsi_lane u_lane (
                .i_taps (taps),
                .i_mode (eff_mode),
                .o_pix  (lane_pix[l])
            );
        end else begin : g_off
            assign lane_pix[l] = '0;
        end
    end

    lvsi_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_ctrl     (ctrl),
        .i_lane_pix (lane_pix),
        .o_ready    (merge_ready),
        .o_pred     (o_pred)
    );

    `LVSI_ASSERT_NEXT(a_start_counts_one, i_clk, i_rst_n,
        take && i_row.block_start, r_count == lvsi_pkg::CNT_W'(1))
    `LVSI_ASSERT_NEXT(a_idle_stays_idle, i_clk, i_rst_n,
        take && !i_row.block_start && r_count == lvsi_pkg::IDLE_COUNT,
        r_count == lvsi_pkg::IDLE_COUNT && !o_pred.valid)
    `LVSI_ASSERT_NEXT(a_ninth_row_is_last, i_clk, i_rst_n,
        take && eff_count == lvsi_pkg::LAST_OUT, o_pred.valid && o_pred.last_row)
    `LVSI_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n,
        o_pred.valid && !o_pred.ready, !i_row.ready)

endmodule

// File: bench/tb_luma_vertical_subpel_interp.sv
`timescale 1ns / 100ps
// self-checking bench for the luma vertical six-tap sub-pel interpolator
// drives reference rows, predicts or looks up each output row, compares it field by field
// depends on lvsi_pkg, lvsi_stream_if and the luma_vertical_subpel_interp rtl
module tb_luma_vertical_subpel_interp;

    typedef struct packed {
        logic [lvsi_pkg::WORD_W-1:0] pixels;
        logic                        last;
    } t_pred_word;

    typedef struct packed {
        logic                        start;
        lvsi_pkg::t_frac_mode        mode;
        logic [lvsi_pkg::WORD_W-1:0] pixels;
        logic                        typed;
        t_pred_word                  want;
    } t_stim_row;

    localparam int RANDOM_ROWS = 450;

    logic i_clk;
    logic i_rst_n;
    logic calm;

    lvsi_row_if  row_ch ();
    lvsi_pred_if pred_ch ();

    luma_vertical_subpel_interp dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row_ch),
        .o_pred  (pred_ch)
    );

    // predictor state
    logic [lvsi_pkg::WORD_W-1:0] tap_rows [lvsi_pkg::WINDOW_ROWS];
    logic [lvsi_pkg::CNT_W-1:0]  rows_taken;
    lvsi_pkg::t_frac_mode        mode_held;

    t_pred_word expected_rows [$];
    int         errors;
    int         stall_left;
    int         sink_gap;

    // idle row, full-pel block, then half-pel and quarter-pel blocks each cut short by a restart
    t_stim_row directed_rows [28] = '{
        '{1'b0, lvsi_pkg::MODE_HALF,       32'hFFFFFFFF, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b1, lvsi_pkg::MODE_FULL,       32'h01234567, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_HALF,       32'h89ABCDEF, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_QUARTER_HI, 32'h00000000, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_QUARTER_LO, 32'hFFFFFFFF, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_FULL,       32'hA5A55A5A, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_FULL,       32'h0F0FF0F0, 1'b1, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_HALF,       32'h3C3CC3C3, 1'b1, '{32'hFFFFFFFF, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_FULL,       32'h80808080, 1'b1, '{32'hA5A55A5A, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_FULL,       32'h7F7F7F7F, 1'b1, '{32'h0F0FF0F0, 1'b1}},
        // lane 0 flat white, lane 1 negative sum, lane 2 overflow, lane 3 black
        '{1'b1, lvsi_pkg::MODE_HALF,       32'h000000FF, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_HALF,       32'h0000FFFF, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_HALF,       32'h00FF00FF, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_HALF,       32'h00FF00FF, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_HALF,       32'h0000FFFF, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_HALF,       32'h000000FF, 1'b1, '{32'h00FF00FF, 1'b0}},
        '{1'b1, lvsi_pkg::MODE_QUARTER_LO, 32'h10FF00A0, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_QUARTER_LO, 32'h2080FF01, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_QUARTER_LO, 32'hFE017F40, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_QUARTER_LO, 32'h55AA33CC, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_QUARTER_LO, 32'h00FFFF00, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_QUARTER_LO, 32'hC3E1F00F, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b1, lvsi_pkg::MODE_QUARTER_HI, 32'hFFFFFFFF, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_QUARTER_HI, 32'h00000000, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_QUARTER_HI, 32'h7F80817E, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_QUARTER_HI, 32'h01020304, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_QUARTER_HI, 32'hF0E0D0C0, 1'b0, '{32'h00000000, 1'b0}},
        '{1'b0, lvsi_pkg::MODE_QUARTER_HI, 32'h89674523, 1'b0, '{32'h00000000, 1'b0}}
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #500000;
        $display("CHECK FAILED");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // advance the interpolator by one row word; returns 1 when an output row is due
    function automatic bit interp_step(input logic start, input lvsi_pkg::t_frac_mode mode,
                                       input logic [lvsi_pkg::WORD_W-1:0] cur,
                                       output t_pred_word w);
        int a, b, c, d, e, f, sum, half, p;
        bit produced;
        w = '0;
        if (start) begin
            mode_held  = mode;
            rows_taken = '0;
        end
        produced = (rows_taken < lvsi_pkg::IDLE_COUNT) && (rows_taken >= lvsi_pkg::FIRST_OUT);
        if (produced) begin
            for (int l = 0; l < lvsi_pkg::ACTIVE_LANES; l++) begin
                a = int'(tap_rows[0][lvsi_pkg::PIX_W*l +: lvsi_pkg::PIX_W]);
                b = int'(tap_rows[1][lvsi_pkg::PIX_W*l +: lvsi_pkg::PIX_W]);
                c = int'(tap_rows[2][lvsi_pkg::PIX_W*l +: lvsi_pkg::PIX_W]);
                d = int'(tap_rows[3][lvsi_pkg::PIX_W*l +: lvsi_pkg::PIX_W]);
                e = int'(tap_rows[4][lvsi_pkg::PIX_W*l +: lvsi_pkg::PIX_W]);
                f = int'(cur[lvsi_pkg::PIX_W*l +: lvsi_pkg::PIX_W]);
                sum = a - 5 * b + 20 * (c + d) - 5 * e + f + lvsi_pkg::ROUND_ADD;
                half = (sum < 0) ? 0 : (sum >>> lvsi_pkg::SHIFT_AMT);
                if (half > 255)
                    half = 255;
                case (mode_held)
                    lvsi_pkg::MODE_FULL:       p = c;
                    lvsi_pkg::MODE_QUARTER_LO: p = (half + c + 1) >> 1;
                    lvsi_pkg::MODE_HALF:       p = half;
                    default:                   p = (half + d + 1) >> 1;
                endcase
                w.pixels[lvsi_pkg::PIX_W*l +: lvsi_pkg::PIX_W] = p[lvsi_pkg::PIX_W-1:0];
            end
            w.last = (rows_taken == lvsi_pkg::LAST_OUT);
        end
        for (int i = 0; i < lvsi_pkg::WINDOW_ROWS - 1; i++)
            tap_rows[i] = tap_rows[i + 1];
        tap_rows[lvsi_pkg::WINDOW_ROWS - 1] = cur;
        if (rows_taken < lvsi_pkg::IDLE_COUNT)
            rows_taken = rows_taken + 1'b1;
        return produced;
    endfunction

    // present one row word and hold it until the handshake
    task automatic push_row(input logic start, input lvsi_pkg::t_frac_mode mode,
                            input logic [lvsi_pkg::WORD_W-1:0] pixels, input logic typed,
                            input t_pred_word typed_word);
        t_pred_word word;
        bit has_word;
        has_word = interp_step(start, mode, pixels, word);
        if (typed)
            expected_rows.push_back(typed_word);
        else if (has_word)
            expected_rows.push_back(word);
        row_ch.valid       <= 1'b1;
        row_ch.block_start <= start;
        row_ch.frac_mode   <= mode;
        row_ch.row_pixels  <= pixels;
        do
            @(posedge i_clk);
        while (!row_ch.ready);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            row_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // result side: random stalls, none during calm stretches
    always @(posedge i_clk) begin
        if (calm) begin
            stall_left    <= 0;
            pred_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            pred_ch.ready <= 1'b0;
        end else begin
            sink_gap = gap_len();
            pred_ch.ready <= (sink_gap == 0);
            stall_left    <= (sink_gap == 0) ? 0 : sink_gap - 1;
        end
    end

    always @(posedge i_clk) begin
        t_pred_word want;
        if (i_rst_n && pred_ch.valid && pred_ch.ready) begin
            if (expected_rows.size() == 0) begin
                $display("%0t unexpected word: pixels %h last %b", $time,
                         pred_ch.pred_pixels, pred_ch.last_row);
                errors++;
            end else begin
                want = expected_rows.pop_front();
                if (pred_ch.pred_pixels !== want.pixels) begin
                    $display("%0t pred_pixels mismatch: expected %h actual %h", $time,
                             want.pixels, pred_ch.pred_pixels);
                    errors++;
                end
                if (pred_ch.last_row !== want.last) begin
                    $display("%0t last_row mismatch: expected %b actual %b", $time,
                             want.last, pred_ch.last_row);
                    errors++;
                end
            end
        end
    end

    initial begin
        int                          sent;
        int                          blk;
        int                          kind;
        int                          len;
        bit                          quiet;
        lvsi_pkg::t_frac_mode        mode;
        logic [lvsi_pkg::WORD_W-1:0] pix;
        int                          r;

        for (int i = 0; i < lvsi_pkg::WINDOW_ROWS; i++)
            tap_rows[i] = '0;
        rows_taken = lvsi_pkg::IDLE_COUNT;
        mode_held  = lvsi_pkg::MODE_FULL;

        i_rst_n            <= 1'b0;
        calm               <= 1'b0;
        row_ch.valid       <= 1'b0;
        row_ch.block_start <= 1'b0;
        row_ch.frac_mode   <= lvsi_pkg::MODE_FULL;
        row_ch.row_pixels  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            push_row(directed_rows[i].start, directed_rows[i].mode, directed_rows[i].pixels,
                     directed_rows[i].typed, directed_rows[i].want);
            idle_gap(gap_len());
        end

        // hold off until the directed words have drained
        row_ch.valid <= 1'b0;
        wait (expected_rows.size() == 0);
        @(posedge i_clk);

        sent = 0;
        blk  = 0;
        while (sent < RANDOM_ROWS) begin
            blk++;
            quiet = (blk % 8 == 3);
            calm <= quiet;
            if (blk % 11 == 5) begin
                row_ch.valid <= 1'b0;
                wait (expected_rows.size() == 0);
                @(posedge i_clk);
            end
            kind = $urandom_range(0, 9);
            // stray rows, a block cut short by the next start, or a whole block
            len = (kind == 0) ? $urandom_range(1, 3) :
                  (kind == 1) ? $urandom_range(1, 8) : lvsi_pkg::ROWS_PER_BLOCK;
            for (int row = 0; row < len; row++) begin
                for (int l = 0; l < lvsi_pkg::WORD_LANES; l++) begin
                    r = $urandom_range(0, 3);
                    pix[lvsi_pkg::PIX_W*l +: lvsi_pkg::PIX_W] =
                        (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
                end
                mode = lvsi_pkg::t_frac_mode'($urandom_range(0, 3));
                push_row((kind != 0) && (row == 0), mode, pix, 1'b0, '0);
                if (kind != 0)
                    sent++;
                idle_gap(quiet ? 0 : gap_len());
            end
        end

        row_ch.valid <= 1'b0;
        calm         <= 1'b0;
        wait (expected_rows.size() == 0);
        repeat (4) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
